// ===== design/alc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the audio looper core.
`default_nettype none
package alc_pkg;

	localparam int LOOP_CAPACITY = 4194304;
	localparam int SAMPLE_BITS   = 24;

	localparam int ADDR_W     = $clog2(LOOP_CAPACITY);
	localparam int LEN_W      = ADDR_W + 1;
	localparam int BEAT_LEN_W = 20;
	localparam int BEAT_CNT_W = BEAT_LEN_W + 1;
	localparam int BEAT_NUM_W = 4;
	localparam int FUNC_W     = 2;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int WIDE_W     = SAMPLE_BITS + 4;

	localparam int IN_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = SAMPLE_BITS + ADDR_W + LEN_W + BEAT_NUM_W;
	localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
	localparam int OUT_TUSER_W   = MODE_W + 2;

	localparam logic [BEAT_LEN_W-1:0] BEAT_LEN_RESET = BEAT_LEN_W'(33103);
	localparam logic [BEAT_NUM_W-1:0] COUNT_IN_RESET = BEAT_NUM_W'(4);

	localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REC    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PLAY   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_BEAT_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_IN    = 1'b1;

	localparam logic [MODE_W-1:0] MC_IDLE  = 3'd0;
	localparam logic [MODE_W-1:0] MC_COUNT = 3'd1;
	localparam logic [MODE_W-1:0] MC_REC   = 3'd2;
	localparam logic [MODE_W-1:0] MC_PLAY  = 3'd3;
	localparam logic [MODE_W-1:0] MC_ODUB  = 3'd4;
	localparam logic [MODE_W-1:0] MC_STOP  = 3'd5;

	localparam logic signed [WIDE_W-1:0] WIDE_MAX =
		{{(WIDE_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] WIDE_MIN =
		{{(WIDE_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [5:0] {
		MODE_IDLE  = 6'b000001,
		MODE_COUNT = 6'b000010,
		MODE_REC   = 6'b000100,
		MODE_PLAY  = 6'b001000,
		MODE_ODUB  = 6'b010000,
		MODE_STOP  = 6'b100000
	} mode_t;

	typedef enum logic [1:0] {
		WET_ZERO,
		WET_DRY,
		WET_MIX
	} wet_sel_t;

	typedef struct packed {
		logic [BEAT_NUM_W-1:0] beats;
		logic [LEN_W-1:0]      len;
		logic [ADDR_W-1:0]     head;
		logic                  click;
		logic                  armed;
		logic [MODE_W-1:0]     mode;
	} status_t;

	typedef struct packed {
		wet_sel_t                      wet_sel;
		logic                          wr_en;
		logic                          wr_odub;
		logic [ADDR_W-1:0]             wr_addr;
		logic signed [SAMPLE_BITS-1:0] dry;
		status_t                       status;
	} op_t;

	function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
		logic [MODE_W-1:0] c;
		unique case (m)
			MODE_IDLE:  c = MC_IDLE;
			MODE_COUNT: c = MC_COUNT;
			MODE_REC:   c = MC_REC;
			MODE_PLAY:  c = MC_PLAY;
			MODE_ODUB:  c = MC_ODUB;
			MODE_STOP:  c = MC_STOP;
			default:    c = MC_IDLE;
		endcase
		return c;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [WIDE_W-1:0] v
	);
		logic signed [SAMPLE_BITS-1:0] r;
		if (v > WIDE_MAX) begin
			r = WIDE_MAX[SAMPLE_BITS-1:0];
		end else if (v < WIDE_MIN) begin
			r = WIDE_MIN[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/alc_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module alc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/alc_ctrl.sv =====
// Mode machine, count-in counters, loop pointers and config registers.
`default_nettype none
module alc_ctrl (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [alc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [alc_pkg::BEAT_LEN_W-1:0]     cfg_data,
	input  wire logic                               accept,
	input  wire logic [alc_pkg::FUNC_W-1:0]         func,
	input  wire logic signed [alc_pkg::SAMPLE_BITS-1:0] dry,
	output alc_pkg::op_t                            op,
	output logic [alc_pkg::ADDR_W-1:0]              rd_addr
);

	alc_pkg::mode_t                     mode_q, mode_d;
	logic [alc_pkg::LEN_W-1:0]          len_q, len_d;
	logic [alc_pkg::ADDR_W-1:0]         head_q, head_d;
	logic                               armed_q, armed_d;
	logic [alc_pkg::BEAT_CNT_W-1:0]     bc_q, bc_d;
	logic [alc_pkg::BEAT_NUM_W-1:0]     bf_q, bf_d;
	logic [alc_pkg::BEAT_LEN_W-1:0]     beat_len_q;
	logic [alc_pkg::BEAT_NUM_W-1:0]     cin_q;

	logic [alc_pkg::LEN_W-1:0]          head_inc;
	logic [alc_pkg::ADDR_W-1:0]         head_wrap;
	logic [alc_pkg::BEAT_CNT_W-1:0]     beat_len_ext;
	logic                               beat_hit;
	logic                               click;

	assign rd_addr      = head_q;
	assign head_inc     = {1'b0, head_q} + alc_pkg::LEN_W'(1);
	assign head_wrap    = (head_inc >= len_q) ? '0 : head_inc[alc_pkg::ADDR_W-1:0];
	assign beat_len_ext = {1'b0, beat_len_q};
	assign beat_hit     = (bc_q >= beat_len_ext);

	always_comb begin
		mode_d     = mode_q;
		len_d      = len_q;
		head_d     = head_q;
		armed_d    = armed_q;
		bc_d       = bc_q;
		bf_d       = bf_q;
		click      = 1'b0;
		op.wet_sel = alc_pkg::WET_ZERO;
		op.wr_en   = 1'b0;
		op.wr_odub = 1'b0;
		op.wr_addr = head_q;
		op.dry     = dry;
		case (func)
			alc_pkg::FUNC_REC: begin
				unique case (mode_q)
					alc_pkg::MODE_IDLE: begin
						bc_d   = beat_len_ext;
						bf_d   = '0;
						mode_d = alc_pkg::MODE_COUNT;
					end
					alc_pkg::MODE_COUNT: mode_d = alc_pkg::MODE_IDLE;
					alc_pkg::MODE_REC: begin
						head_d = '0;
						mode_d = alc_pkg::MODE_PLAY;
					end
					alc_pkg::MODE_PLAY: armed_d = ~armed_q;
					alc_pkg::MODE_ODUB: mode_d = alc_pkg::MODE_PLAY;
					alc_pkg::MODE_STOP: begin
						head_d = '0;
						mode_d = alc_pkg::MODE_ODUB;
					end
					default: ;
				endcase
			end
			alc_pkg::FUNC_PLAY: begin
				unique case (mode_q)
					alc_pkg::MODE_COUNT: mode_d = alc_pkg::MODE_IDLE;
					alc_pkg::MODE_REC: begin
						head_d = '0;
						mode_d = alc_pkg::MODE_PLAY;
					end
					alc_pkg::MODE_PLAY: begin
						armed_d = 1'b0;
						mode_d  = alc_pkg::MODE_STOP;
					end
					alc_pkg::MODE_ODUB: mode_d = alc_pkg::MODE_STOP;
					alc_pkg::MODE_STOP: begin
						head_d = '0;
						mode_d = alc_pkg::MODE_PLAY;
					end
					default: ;
				endcase
			end
			alc_pkg::FUNC_CLEAR: begin
				len_d   = '0;
				head_d  = '0;
				armed_d = 1'b0;
				mode_d  = alc_pkg::MODE_IDLE;
			end
			default: begin
				unique case (mode_q)
					alc_pkg::MODE_COUNT: begin
						op.wet_sel = alc_pkg::WET_DRY;
						if (beat_hit) begin
							if (bf_q >= cin_q) begin
								len_d  = '0;
								head_d = '0;
								mode_d = alc_pkg::MODE_REC;
							end else begin
								click = 1'b1;
								bf_d  = bf_q + alc_pkg::BEAT_NUM_W'(1);
							end
						end
						bc_d = (beat_hit ? '0 : bc_q) + alc_pkg::BEAT_CNT_W'(1);
					end
					alc_pkg::MODE_REC: begin
						op.wet_sel = alc_pkg::WET_DRY;
						if (len_q < alc_pkg::LEN_W'(alc_pkg::LOOP_CAPACITY)) begin
							op.wr_en   = 1'b1;
							op.wr_addr = len_q[alc_pkg::ADDR_W-1:0];
							len_d      = len_q + alc_pkg::LEN_W'(1);
						end else begin
							head_d = '0;
							mode_d = alc_pkg::MODE_PLAY;
						end
					end
					alc_pkg::MODE_PLAY: begin
						if (len_q != '0) begin
							op.wet_sel = alc_pkg::WET_MIX;
							head_d     = head_wrap;
							if (armed_q && head_wrap == '0) begin
								armed_d = 1'b0;
								mode_d  = alc_pkg::MODE_ODUB;
							end
						end
					end
					alc_pkg::MODE_ODUB: begin
						if (len_q != '0) begin
							op.wet_sel = alc_pkg::WET_MIX;
							op.wr_en   = 1'b1;
							op.wr_odub = 1'b1;
							head_d     = head_wrap;
						end
					end
					default: op.wet_sel = alc_pkg::WET_DRY;
				endcase
			end
		endcase
		op.status.mode  = alc_pkg::mode_code(mode_d);
		op.status.armed = armed_d;
		op.status.click = click;
		op.status.head  = head_d;
		op.status.len   = len_d;
		op.status.beats = bf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= alc_pkg::MODE_IDLE;
			len_q      <= '0;
			head_q     <= '0;
			armed_q    <= 1'b0;
			bc_q       <= '0;
			bf_q       <= '0;
			beat_len_q <= alc_pkg::BEAT_LEN_RESET;
			cin_q      <= alc_pkg::COUNT_IN_RESET;
		end else begin
			if (accept) begin
				mode_q  <= mode_d;
				len_q   <= len_d;
				head_q  <= head_d;
				armed_q <= armed_d;
				bc_q    <= bc_d;
				bf_q    <= bf_d;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					alc_pkg::CFG_BEAT_LENGTH: beat_len_q <= cfg_data;
					alc_pkg::CFG_COUNT_IN:
						cin_q <= cfg_data[alc_pkg::BEAT_NUM_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/alc_mix.sv =====
// Memory-read stage: forwarding, mix, overdub write-back and output register.
`default_nettype none
module alc_mix (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire alc_pkg::op_t                        op,
	input  wire logic [alc_pkg::ADDR_W-1:0]          rd_addr,
	input  wire logic [alc_pkg::SAMPLE_BITS-1:0]     rd_data,
	output logic                                     in_ready,
	output logic                                     wr_en,
	output logic [alc_pkg::ADDR_W-1:0]               wr_addr,
	output logic [alc_pkg::SAMPLE_BITS-1:0]          wr_data,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [alc_pkg::OUT_TDATA_W-1:0]          m_tdata,
	output logic [alc_pkg::OUT_TUSER_W-1:0]          m_tuser
);

	localparam int SB = alc_pkg::SAMPLE_BITS;
	localparam int WW = alc_pkg::WIDE_W;

	logic                              valid_s1;
	alc_pkg::op_t                      op_s1;
	logic                              fwd_s1;
	logic [SB-1:0]                     fwd_data_s1;

	logic                              out_valid_q;
	logic [alc_pkg::OUT_TDATA_W-1:0]   out_tdata_q;
	logic [alc_pkg::OUT_TUSER_W-1:0]   out_tuser_q;

	logic                              adv;
	logic signed [SB-1:0]              old;
	logic signed [WW-1:0]              old_w, dry_w, mix_sum, odub_sum;
	logic signed [SB-1:0]              mix_sat, odub_sat, wet;

	assign adv      = !out_valid_q || m_tready;
	assign in_ready = !valid_s1 || adv;

	assign old      = fwd_s1 ? fwd_data_s1 : rd_data;
	assign old_w    = {{(WW-SB){old[SB-1]}}, old};
	assign dry_w    = {{(WW-SB){op_s1.dry[SB-1]}}, op_s1.dry};
	assign mix_sum  = old_w + dry_w;
	// floor((3*old + 2*dry + 2) / 4)
	assign odub_sum = ((old_w <<< 1) + old_w + (dry_w <<< 1) + WW'(2)) >>> 2;
	assign mix_sat  = alc_pkg::sat_sample(mix_sum);
	assign odub_sat = alc_pkg::sat_sample(odub_sum);

	always_comb begin
		case (op_s1.wet_sel)
			alc_pkg::WET_DRY: wet = op_s1.dry;
			alc_pkg::WET_MIX: wet = mix_sat;
			default:          wet = '0;
		endcase
	end

	assign wr_en   = valid_s1 && adv && op_s1.wr_en;
	assign wr_addr = op_s1.wr_addr;
	assign wr_data = op_s1.wr_odub ? odub_sat : op_s1.dry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op;
			fwd_s1      <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
		if (adv && valid_s1) begin
			out_tdata_q <= alc_pkg::OUT_TDATA_W'({op_s1.status.beats, op_s1.status.len,
				op_s1.status.head, wet});
			out_tuser_q <= {op_s1.status.click, op_s1.status.armed, op_s1.status.mode};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_tdata_q;
	assign m_tuser  = out_tuser_q;

endmodule
`default_nettype wire

// ===== design/audio_looper_core.sv =====
// The input transaction loads the stage-1 register, then the output register
// that drives m_tvalid. Throughput: one item per cycle unless m_tready stalls;
// the loop memory read issues on accept and the write-back or record write
// is made from the stage-1 register as it advances, with forwarding.
// Reset: arst_n clears mode, pointers, counters and handshake state and loads
// the register defaults; the loop memory is not cleared.
`default_nettype none
module audio_looper_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [alc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [alc_pkg::BEAT_LEN_W-1:0]      cfg_data,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [alc_pkg::IN_TDATA_W-1:0]      s_tdata,  // dry_sample
	input  wire logic [alc_pkg::FUNC_W-1:0]          s_tuser,  // func
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// wet_sample, play_position, recorded_length, beat_number
	output logic [alc_pkg::OUT_TDATA_W-1:0]          m_tdata,
	// mode_now, armed_now, click_start
	output logic [alc_pkg::OUT_TUSER_W-1:0]          m_tuser
);

	logic                                accept;
	alc_pkg::op_t                        op;
	logic [alc_pkg::ADDR_W-1:0]          rd_addr;
	logic [alc_pkg::SAMPLE_BITS-1:0]     rd_data;
	logic                                wr_en;
	logic [alc_pkg::ADDR_W-1:0]          wr_addr;
	logic [alc_pkg::SAMPLE_BITS-1:0]     wr_data;

	assign accept = s_tvalid && s_tready;

	alc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.func      (s_tuser),
		.dry       (s_tdata[alc_pkg::SAMPLE_BITS-1:0]),
		.op        (op),
		.rd_addr   (rd_addr)
	);

	alc_ram #(
		.WIDTH (alc_pkg::SAMPLE_BITS),
		.DEPTH (alc_pkg::LOOP_CAPACITY)
	) u_loop_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	alc_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.op       (op),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.in_ready (s_tready),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

// ===== design/alc_checker.sv =====
// Port-level checks for the audio looper core, bound to the top level.
`default_nettype none
module alc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [alc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic [alc_pkg::OUT_TUSER_W-1:0] m_tuser
);

	localparam int SB = alc_pkg::SAMPLE_BITS;
	localparam int AW = alc_pkg::ADDR_W;
	localparam int LW = alc_pkg::LEN_W;
	localparam int MW = alc_pkg::MODE_W;

	logic [AW-1:0] pos;
	logic [LW-1:0] len;
	logic [MW-1:0] mode;

	assign pos  = m_tdata[SB+AW-1:SB];
	assign len  = m_tdata[SB+AW+LW-1:SB+AW];
	assign mode = m_tuser[MW-1:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_head_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, pos} < len || pos == '0))
		else $error("play position outside recorded loop");

	a_click_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[MW+1] |-> mode == alc_pkg::MC_COUNT)
		else $error("click outside count-in");

	a_armed_play: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[MW] |-> mode == alc_pkg::MC_PLAY)
		else $error("overdub armed outside playback");

endmodule

bind audio_looper_core alc_checker u_alc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== dv/looper_result_check.sv =====
// Checker for the looper core: tracks every transaction, predicts each result, compares it.
`timescale 1ns / 1ps
module looper_result_check import alc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [BEAT_LEN_W-1:0]  cfg_data,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic [FUNC_W-1:0]      s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	input  wire logic [OUT_TUSER_W-1:0] m_tuser,
	output int                          mismatches,
	output int                          outstanding
);

	localparam int POS_LSB   = SAMPLE_BITS;
	localparam int LEN_LSB   = POS_LSB + ADDR_W;
	localparam int BEATS_LSB = LEN_LSB + LEN_W;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] wet;
		logic [MODE_W-1:0]      mode;
		logic                   armed;
		logic                   click;
		logic [ADDR_W-1:0]      pos;
		logic [LEN_W-1:0]       len;
		logic [BEAT_NUM_W-1:0]  beats;
	} looper_out_t;

	// predicted looper state
	logic [BEAT_LEN_W-1:0]         beat_len;
	logic [BEAT_NUM_W-1:0]         count_in;
	logic [MODE_W-1:0]             lp_mode;
	int unsigned                   rec_len;
	int unsigned                   head_pos;
	logic                          arm;
	logic [BEAT_CNT_W-1:0]         beat_cnt;
	logic [BEAT_NUM_W-1:0]         clicks_done;
	logic signed [SAMPLE_BITS-1:0] loop_store [int unsigned];

	looper_out_t predicted_outputs [$];
	looper_out_t want, got, fresh;

	function automatic logic signed [SAMPLE_BITS-1:0] clip(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			v = hi;
		end else if (v < lo) begin
			v = lo;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	function automatic longint fetch(input int unsigned a);
		if (loop_store.exists(a)) begin
			return longint'(loop_store[a]);
		end
		return 0;
	endfunction

	function automatic void step_head();
		int unsigned n;
		n = head_pos + 1;
		head_pos = (n >= rec_len) ? 0 : n;
	endfunction

	task automatic looper_step(input logic [FUNC_W-1:0] f,
			input logic signed [SAMPLE_BITS-1:0] dry, output looper_out_t r);
		longint old;
		r = '0;
		case (f)
			FUNC_REC: begin
				case (lp_mode)
					MC_IDLE: begin
						beat_cnt = BEAT_CNT_W'(beat_len);
						clicks_done = '0;
						lp_mode = MC_COUNT;
					end
					MC_COUNT: lp_mode = MC_IDLE;
					MC_REC: begin
						head_pos = 0;
						lp_mode = MC_PLAY;
					end
					MC_PLAY: arm = ~arm;
					MC_ODUB: lp_mode = MC_PLAY;
					MC_STOP: begin
						head_pos = 0;
						lp_mode = MC_ODUB;
					end
					default: ;
				endcase
			end
			FUNC_PLAY: begin
				case (lp_mode)
					MC_COUNT: lp_mode = MC_IDLE;
					MC_REC: begin
						head_pos = 0;
						lp_mode = MC_PLAY;
					end
					MC_PLAY: begin
						arm = 1'b0;
						lp_mode = MC_STOP;
					end
					MC_ODUB: lp_mode = MC_STOP;
					MC_STOP: begin
						head_pos = 0;
						lp_mode = MC_PLAY;
					end
					default: ;
				endcase
			end
			FUNC_CLEAR: begin
				rec_len = 0;
				head_pos = 0;
				arm = 1'b0;
				lp_mode = MC_IDLE;
			end
			default: begin
				case (lp_mode)
					MC_COUNT: begin
						r.wet = dry;
						if (beat_cnt >= BEAT_CNT_W'(beat_len)) begin
							beat_cnt = '0;
							if (clicks_done >= count_in) begin
								rec_len = 0;
								head_pos = 0;
								lp_mode = MC_REC;
							end else begin
								r.click = 1'b1;
								clicks_done = clicks_done + 1'b1;
							end
						end
						beat_cnt = beat_cnt + 1'b1;
					end
					MC_REC: begin
						if (rec_len < LOOP_CAPACITY) begin
							loop_store[rec_len] = dry;
							rec_len++;
						end else begin
							head_pos = 0;
							lp_mode = MC_PLAY;
						end
						r.wet = dry;
					end
					MC_PLAY: begin
						if (rec_len != 0) begin
							r.wet = clip(fetch(head_pos) + dry);
							step_head();
							if (arm && head_pos == 0) begin
								arm = 1'b0;
								lp_mode = MC_ODUB;
							end
						end
					end
					MC_ODUB: begin
						if (rec_len != 0) begin
							old = fetch(head_pos);
							// floor((3*old + 2*dry + 2) / 4): halves round up
							loop_store[head_pos] = clip((3 * old + 2 * dry + 2) >>> 2);
							r.wet = clip(old + dry);
							step_head();
						end
					end
					default: r.wet = dry;
				endcase
			end
		endcase
		r.mode  = lp_mode;
		r.armed = arm;
		r.pos   = head_pos[ADDR_W-1:0];
		r.len   = rec_len[LEN_W-1:0];
		r.beats = clicks_done;
	endtask

	function automatic void check_field(input string name, input logic [31:0] e,
			input logic [31:0] a);
		if (e !== a) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_len    = BEAT_LEN_RESET;
			count_in    = COUNT_IN_RESET;
			lp_mode     = MC_IDLE;
			rec_len     = 0;
			head_pos    = 0;
			arm         = 1'b0;
			beat_cnt    = '0;
			clicks_done = '0;
			predicted_outputs.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_BEAT_LENGTH) begin
					beat_len = cfg_data;
				end else begin
					count_in = cfg_data[BEAT_NUM_W-1:0];
				end
			end
			if (m_tvalid && m_tready) begin
				got.wet   = m_tdata[SAMPLE_BITS-1:0];
				got.pos   = m_tdata[POS_LSB +: ADDR_W];
				got.len   = m_tdata[LEN_LSB +: LEN_W];
				got.beats = m_tdata[BEATS_LSB +: BEAT_NUM_W];
				got.mode  = m_tuser[MODE_W-1:0];
				got.armed = m_tuser[MODE_W];
				got.click = m_tuser[MODE_W+1];
				if (predicted_outputs.size() == 0) begin
					$display("%0t ns: unexpected transaction, expected none, actual 0x%0h",
						$time, got);
					mismatches++;
				end else begin
					want = predicted_outputs.pop_front();
					check_field("wet_sample", 32'(want.wet), 32'(got.wet));
					check_field("mode_now", 32'(want.mode), 32'(got.mode));
					check_field("armed_now", 32'(want.armed), 32'(got.armed));
					check_field("click_start", 32'(want.click), 32'(got.click));
					check_field("play_position", 32'(want.pos), 32'(got.pos));
					check_field("recorded_length", 32'(want.len), 32'(got.len));
					check_field("beat_number", 32'(want.beats), 32'(got.beats));
				end
			end
			if (s_tvalid && s_tready) begin
				looper_step(s_tuser, s_tdata[SAMPLE_BITS-1:0], fresh);
				predicted_outputs.push_back(fresh);
			end
		end
		outstanding = predicted_outputs.size();
	end

endmodule

// ===== dv/tb_audio_looper_core.sv =====
// Testbench top for the looper core: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps
module tb_audio_looper_core;
	import alc_pkg::*;

	localparam int RANDOM_ITEMS = 1250;
	localparam int STALL_LIMIT  = 2000;
	localparam logic [SAMPLE_BITS-1:0] PEAK_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] PEAK_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [BEAT_LEN_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;    // dry_sample
	logic [FUNC_W-1:0]      s_tuser = '0;    // func
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // wet_sample, play_position, recorded_length,
	                                         // beat_number
	logic [OUT_TUSER_W-1:0] m_tuser;         // mode_now, armed_now, click_start

	int mismatches;
	int outstanding;
	int quiet_cycles = 0;
	int items_sent = 0;
	bit gaps_on = 1'b1;

	audio_looper_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	looper_result_check checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		m_tready <= gaps_on ? ($urandom_range(99) >= 7) : 1'b1;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(15))
			0:       return PEAK_POS;
			1:       return PEAK_NEG;
			2:       return '0;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// called just after a falling edge, returns just after a falling edge
	task automatic push_item(input logic [FUNC_W-1:0] f, input logic [SAMPLE_BITS-1:0] d);
		while (gaps_on && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= IN_TDATA_W'(d);
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BEAT_LEN_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int session;
		int stop_at;
		int r;
		int n_count;
		logic [BEAT_LEN_W-1:0] bl;
		logic [BEAT_NUM_W-1:0] cin;
		logic [FUNC_W-1:0] f;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults: idle passthrough, count-in start and abort
		push_item(FUNC_SAMPLE, PEAK_POS);
		push_item(FUNC_PLAY, rand_sample());
		push_item(FUNC_REC, rand_sample());
		push_item(FUNC_SAMPLE, PEAK_NEG);
		push_item(FUNC_SAMPLE, rand_sample());
		push_item(FUNC_PLAY, rand_sample());

		// largest registers
		settle();
		write_reg(CFG_BEAT_LENGTH, '1);
		write_reg(CFG_COUNT_IN, '1);
		push_item(FUNC_REC, rand_sample());
		push_item(FUNC_SAMPLE, rand_sample());
		push_item(FUNC_SAMPLE, rand_sample());
		push_item(FUNC_REC, rand_sample());

		// zero beat length, no clicks, empty loop in play, arm, stop and overdub
		settle();
		write_reg(CFG_BEAT_LENGTH, '0);
		write_reg(CFG_COUNT_IN, '0);
		push_item(FUNC_REC, rand_sample());
		push_item(FUNC_SAMPLE, rand_sample());
		push_item(FUNC_REC, rand_sample());
		push_item(FUNC_SAMPLE, PEAK_POS);
		push_item(FUNC_REC, rand_sample());
		push_item(FUNC_SAMPLE, PEAK_NEG);
		push_item(FUNC_PLAY, rand_sample());
		push_item(FUNC_REC, rand_sample());
		push_item(FUNC_SAMPLE, PEAK_POS);
		push_item(FUNC_CLEAR, rand_sample());

		// beat length changed in the middle of a count-in
		settle();
		write_reg(CFG_BEAT_LENGTH, BEAT_LEN_W'(3));
		write_reg(CFG_COUNT_IN, BEAT_LEN_W'(1));
		push_item(FUNC_REC, rand_sample());
		push_item(FUNC_SAMPLE, rand_sample());
		settle();
		write_reg(CFG_BEAT_LENGTH, BEAT_LEN_W'(1));
		push_item(FUNC_SAMPLE, rand_sample());

		stop_at = items_sent + RANDOM_ITEMS;
		session = 0;
		while (items_sent < stop_at) begin
			gaps_on = !(session >= 4 && session < 9);
			settle();
			r = $urandom_range(99);
			if (r < 70) begin
				bl = BEAT_LEN_W'($urandom_range(3));
			end else if (r < 90) begin
				bl = BEAT_LEN_W'($urandom_range(12, 4));
			end else if (r < 95) begin
				bl = '1;
			end else begin
				bl = BEAT_LEN_W'($urandom());
			end
			r = $urandom_range(99);
			cin = (r < 10) ? '1 : (r < 25) ? '0 : BEAT_NUM_W'($urandom_range(4));
			write_reg(CFG_BEAT_LENGTH, bl);
			// upper data bits are don't-care for the count-in register
			write_reg(CFG_COUNT_IN, {(BEAT_LEN_W-BEAT_NUM_W)'($urandom()), cin});
			if ($urandom_range(9) == 0) begin
				repeat (24) push_item(FUNC_W'($urandom_range(3)), rand_sample());
			end else begin
				push_item(FUNC_CLEAR, rand_sample());
				push_item(FUNC_REC, rand_sample());
				n_count = 1 + int'(cin) * ((bl == 0) ? 1 : int'(bl));
				if (n_count > 200) begin
					n_count = 30;
				end
				repeat (n_count) push_item(FUNC_SAMPLE, rand_sample());
				repeat (($urandom_range(9) == 0) ? 0 : $urandom_range(20, 1))
					push_item(FUNC_SAMPLE, rand_sample());
				push_item($urandom_range(1) ? FUNC_REC : FUNC_PLAY, rand_sample());
				repeat ($urandom_range(120, 40)) begin
					r = $urandom_range(99);
					f = (r < 86) ? FUNC_SAMPLE : (r < 93) ? FUNC_REC :
						(r < 99) ? FUNC_PLAY : FUNC_CLEAR;
					push_item(f, rand_sample());
				end
			end
			session++;
		end

		settle();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
